>>> hw/rtl/fsos_pkg.sv
// Package for the frame slot ownership scoreboard.
// Field widths, command, status and register codes, and the payload types.
// Used by the channel interfaces, by fsos_update and by the scoreboard top level.
package fsos_pkg;

  localparam int MAX_FRAMES_DEF     = 64;
  localparam int PRODUCER_SLOTS_DEF = 8;
  localparam int CONSUMER_SLOTS_DEF = 8;

  localparam int CMD_W      = 3;
  localparam int FRAME_W    = 6;
  localparam int SLOT_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int MASK_W     = 8;

  localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PROD_DONE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CONS_DONE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ZERO_DONE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SHUTDOWN  = 3'd4;

  localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STS_NOT_REG   = 2'd1;
  localparam logic [STATUS_W-1:0] STS_DONE      = 2'd2;
  localparam logic [STATUS_W-1:0] STS_OUT_RANGE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRODUCER_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONSUMER_MASK = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_ON_EMPTY = 2'd3;

  localparam logic [COUNT_W-1:0] FRAMES_IN_USE_RST = 7'd64;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [FRAME_W-1:0] frame_index;
    logic [SLOT_W-1:0]  producer_index;
    logic [SLOT_W-1:0]  consumer_index;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                frame_full;
    logic                producer_may_fill;
    logic                consumer_may_read;
    logic                became_full;
    logic                became_empty;
    logic                start_zeroing;
    logic [COUNT_W-1:0]  full_count;
    logic                shut_down;
  } out_item_t;

  // per-item flags from the update logic to the top level
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                frame_full;
    logic                producer_may_fill;
    logic                consumer_may_read;
    logic                became_full;
    logic                became_empty;
    logic                start_zeroing;
  } upd_flags_t;

endpackage

>>> hw/rtl/fsos_if.sv
// Valid/ready channel interfaces for the scoreboard's item and result streams.
// Depends on fsos_pkg for the payload types.
interface fsos_in_if;
  logic               valid;
  logic               ready;
  fsos_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fsos_out_if;
  logic                valid;
  logic                ready;
  fsos_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/fsos_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fsos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/fsos_update.sv
// Read-modify-write logic for one frame entry: done bits, full flag, result flags.
// Depends on fsos_pkg.
module fsos_update #(
  parameter int PS = fsos_pkg::PRODUCER_SLOTS_DEF,
  parameter int CS = fsos_pkg::CONSUMER_SLOTS_DEF
) (
  input  fsos_pkg::in_item_t   item,
  input  logic                 in_range,
  input  logic [PS-1:0]        pmask,
  input  logic [CS-1:0]        cmask,
  input  logic                 zero_on_empty,
  input  logic                 shut_nxt,
  input  logic                 full_old,
  input  logic [PS-1:0]        pdone_old,
  input  logic [CS-1:0]        cdone_old,
  output logic                 full_new,
  output logic [PS-1:0]        pdone_new,
  output logic [CS-1:0]        cdone_new,
  output fsos_pkg::upd_flags_t flags
);

  logic [PS-1:0] pbit;
  logic [CS-1:0] cbit;
  logic [PS-1:0] pd;
  logic [CS-1:0] cd;
  logic          fl;

  assign pbit = PS'(1) << item.producer_index;
  assign cbit = CS'(1) << item.consumer_index;

  always_comb begin
    pd    = pdone_old;
    cd    = cdone_old;
    fl    = full_old;
    flags = '0;
    if (item.cmd == fsos_pkg::CMD_SHUTDOWN) begin
      flags.status = fsos_pkg::STS_OK;
    end else if (!in_range) begin
      flags.status = fsos_pkg::STS_OUT_RANGE;
    end else begin
      case (item.cmd)
        fsos_pkg::CMD_PROD_DONE: begin
          if (!(|(pmask & pbit))) begin
            flags.status = fsos_pkg::STS_NOT_REG;
          end else if (|(pdone_old & pbit)) begin
            flags.status = fsos_pkg::STS_DONE;
          end else begin
            pd = pdone_old | pbit;
            if ((pd & pmask) == pmask) begin
              pd = '0;
              fl = 1'b1;
              flags.became_full = 1'b1;
              if ((cdone_old & cmask) == cmask) begin
                fl = 1'b0;
                cd = '0;
                flags.became_empty = 1'b1;
              end
            end
          end
        end
        fsos_pkg::CMD_CONS_DONE: begin
          if (!(|(cmask & cbit))) begin
            flags.status = fsos_pkg::STS_NOT_REG;
          end else if (|(cdone_old & cbit)) begin
            flags.status = fsos_pkg::STS_DONE;
          end else begin
            cd = cdone_old | cbit;
            if ((cd & cmask) == cmask) begin
              if (zero_on_empty) begin
                flags.start_zeroing = 1'b1;
              end else begin
                fl = 1'b0;
                cd = '0;
                flags.became_empty = 1'b1;
              end
            end
          end
        end
        fsos_pkg::CMD_ZERO_DONE: begin
          fl = 1'b0;
          cd = '0;
          flags.became_empty = 1'b1;
        end
        default: begin
        end
      endcase
    end
    if (in_range) begin
      flags.frame_full        = fl;
      flags.producer_may_fill = (!fl && !(|(pd & pbit))) || shut_nxt;
      flags.consumer_may_read = (fl && !(|(cd & cbit))) || shut_nxt;
    end
  end

  assign full_new  = fl;
  assign pdone_new = pd;
  assign cdone_new = cd;

endmodule

>>> hw/rtl/frame_slot_ownership_scoreboard.sv
// Frame slot ownership scoreboard: tracks full flags and per-party done bits of a frame ring.
// Frame state lives in one fsos_ram; fsos_update does the read-modify-write.
// Depends on fsos_pkg, fsos_in_if/fsos_out_if, fsos_ram and fsos_update.
//
// Each item is handled in a transfer cycle, which issues the frame entry read, and then
// an update cycle, which updates the entry, writes it back and loads the result
// register. The frame memory's registered read data and the one-item-at-a-time
// control set this split; one item is in flight at a time, so no forwarding is needed.
// A held result register stalls the update cycle until the result transfers.
// After reset a clearing pass writes zero to every entry of the frame memory;
// no item is accepted during it, configuration writes are taken throughout.
module frame_slot_ownership_scoreboard #(
  parameter int MAX_FRAMES     = fsos_pkg::MAX_FRAMES_DEF,
  parameter int PRODUCER_SLOTS = fsos_pkg::PRODUCER_SLOTS_DEF,
  parameter int CONSUMER_SLOTS = fsos_pkg::CONSUMER_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  fsos_in_if.sink                         in_ch,
  fsos_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [fsos_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fsos_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam int PS = PRODUCER_SLOTS;
  localparam int CS = CONSUMER_SLOTS;
  localparam int EW = 1 + PS + CS;
  localparam int FW = fsos_pkg::FRAME_W;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC} state_t;

  state_t                         state_r;
  logic [AW-1:0]                  clr_addr_r;
  fsos_pkg::in_item_t             item_r;
  logic [fsos_pkg::COUNT_W-1:0]   fiu_r;
  logic [fsos_pkg::MASK_W-1:0]    pmask_cfg_r;
  logic [fsos_pkg::MASK_W-1:0]    cmask_cfg_r;
  logic                           zoe_r;
  logic                           shut_r;
  logic                           shut_nxt;
  logic [CW-1:0]                  cnt_r;
  logic [CW-1:0]                  cnt_nxt;
  logic                           out_valid_r;
  fsos_pkg::out_item_t            out_data_r;

  logic                           in_xfer;
  logic                           exec_fire;
  logic                           in_range;
  logic [PS-1:0]                  pmask;
  logic [CS-1:0]                  cmask;
  logic [PS+fsos_pkg::MASK_W-1:0] pmask_ext;
  logic [CS+fsos_pkg::MASK_W-1:0] cmask_ext;
  logic [AW+FW-1:0]               in_addr_ext;
  logic [AW+FW-1:0]               item_addr_ext;
  logic [CW+fsos_pkg::COUNT_W-1:0] cnt_ext;

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [EW-1:0]                  ram_wdata;
  logic [AW-1:0]                  ram_raddr;
  logic [EW-1:0]                  ram_rdata;

  logic                           full_new;
  logic [PS-1:0]                  pdone_new;
  logic [CS-1:0]                  cdone_new;
  fsos_pkg::upd_flags_t           flags;

  assign pmask_ext = {{PS{1'b0}}, pmask_cfg_r};
  assign cmask_ext = {{CS{1'b0}}, cmask_cfg_r};
  assign pmask     = pmask_ext[PS-1:0];
  assign cmask     = cmask_ext[CS-1:0];

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign exec_fire   = (state_r == ST_EXEC) && (!out_valid_r || out_ch.ready);

  assign in_addr_ext   = {{AW{1'b0}}, in_ch.data.frame_index};
  assign item_addr_ext = {{AW{1'b0}}, item_r.frame_index};

  assign in_range = ({1'b0, item_r.frame_index} < fiu_r) &&
                    (32'(item_r.frame_index) < MAX_FRAMES);

  assign shut_nxt = shut_r || (item_r.cmd == fsos_pkg::CMD_SHUTDOWN);

  fsos_update #(
    .PS (PS),
    .CS (CS)
  ) u_update (
    .item          (item_r),
    .in_range      (in_range),
    .pmask         (pmask),
    .cmask         (cmask),
    .zero_on_empty (zoe_r),
    .shut_nxt      (shut_nxt),
    .full_old      (ram_rdata[EW-1]),
    .pdone_old     (ram_rdata[PS+CS-1:CS]),
    .cdone_old     (ram_rdata[CS-1:0]),
    .full_new      (full_new),
    .pdone_new     (pdone_new),
    .cdone_new     (cdone_new),
    .flags         (flags)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_range && full_new && !ram_rdata[EW-1]) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (in_range && !full_new && ram_rdata[EW-1] && (cnt_r != '0)) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  assign cnt_ext = {{fsos_pkg::COUNT_W{1'b0}}, cnt_nxt};

  // hold the item's entry address while the update cycle waits
  assign ram_raddr = (state_r == ST_EXEC) ? item_addr_ext[AW-1:0] : in_addr_ext[AW-1:0];
  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = exec_fire && in_range;
      ram_waddr = item_addr_ext[AW-1:0];
      ram_wdata = {full_new, pdone_new, cdone_new};
    end
  end

  fsos_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_FRAMES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fiu_r       <= fsos_pkg::FRAMES_IN_USE_RST;
      pmask_cfg_r <= '0;
      cmask_cfg_r <= '0;
      zoe_r       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        fsos_pkg::REG_FRAMES_IN_USE: fiu_r       <= cfg_data[fsos_pkg::COUNT_W-1:0];
        fsos_pkg::REG_PRODUCER_MASK: pmask_cfg_r <= cfg_data;
        fsos_pkg::REG_CONSUMER_MASK: cmask_cfg_r <= cfg_data;
        fsos_pkg::REG_ZERO_ON_EMPTY: zoe_r       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= in_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      shut_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !exec_fire) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == AW'(MAX_FRAMES - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_xfer) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_fire) begin
            shut_r      <= shut_nxt;
            cnt_r       <= cnt_nxt;
            out_valid_r <= 1'b1;
            out_data_r  <= '{
              status:            flags.status,
              frame_full:        flags.frame_full,
              producer_may_fill: flags.producer_may_fill,
              consumer_may_read: flags.consumer_may_read,
              became_full:       flags.became_full,
              became_empty:      flags.became_empty,
              start_zeroing:     flags.start_zeroing,
              full_count:        cnt_ext[fsos_pkg::COUNT_W-1:0],
              shut_down:         shut_nxt
            };
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// Testbench for frame_slot_ownership_scoreboard: directed table, random frame lifecycles, then shutdown.
// Results are checked in order against an in-bench ownership predictor or typed-in expected values.
// Depends on fsos_pkg, fsos_in_if/fsos_out_if and the scoreboard RTL.
module tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 150;
  localparam int TAIL_ITEMS   = 80;
  localparam int DRAIN_CYCLES = 8;

  typedef enum bit {ROW_ITEM, ROW_REG} row_kind_t;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    row_kind_t                       kind;
    fsos_pkg::in_item_t              item;
    logic [fsos_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [fsos_pkg::CFG_DATA_W-1:0] reg_val;
    bit                              typed;
    fsos_pkg::out_item_t             want;
  } plan_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [fsos_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [fsos_pkg::CFG_DATA_W-1:0] cfg_data;

  fsos_in_if  in_ch ();
  fsos_out_if out_ch ();

  frame_slot_ownership_scoreboard uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // predictor copy of registers and frame state
  logic [fsos_pkg::COUNT_W-1:0] reg_frames;
  logic [fsos_pkg::MASK_W-1:0]  reg_pmask;
  logic [fsos_pkg::MASK_W-1:0]  reg_cmask;
  logic                         reg_zero;
  logic                         frame_full_q [fsos_pkg::MAX_FRAMES_DEF];
  logic [fsos_pkg::MASK_W-1:0]  prod_done_q [fsos_pkg::MAX_FRAMES_DEF];
  logic [fsos_pkg::MASK_W-1:0]  cons_done_q [fsos_pkg::MAX_FRAMES_DEF];
  logic [fsos_pkg::COUNT_W-1:0] full_total;
  logic                         shutdown_seen;

  fsos_pkg::out_item_t pending_results [$];
  plan_row_t           plan [$];
  fsos_pkg::out_item_t oldest;
  int        error_count = 0;
  int        cycle_count = 0;
  int        items_sent = 0;
  int        send_pct = 0;
  int        recv_pct = 0;
  bit        holding = 1'b0;
  bit        allow_shutdown = 1'b0;
  event      hold_off_ev;

  function automatic void set_frame_full(int f, logic v);
    if (v && !frame_full_q[f]) full_total = full_total + 1'b1;
    else if (!v && frame_full_q[f] && full_total != '0) full_total = full_total - 1'b1;
    frame_full_q[f] = v;
  endfunction

  function automatic fsos_pkg::out_item_t advance_ownership(fsos_pkg::in_item_t it);
    fsos_pkg::out_item_t         r;
    logic [fsos_pkg::MASK_W-1:0] pbit;
    logic [fsos_pkg::MASK_W-1:0] cbit;
    logic                        in_range;
    int                          f;
    r = '0;
    f = it.frame_index;
    pbit = 8'd1 << it.producer_index;
    cbit = 8'd1 << it.consumer_index;
    in_range = {1'b0, it.frame_index} < reg_frames;
    if (it.cmd == fsos_pkg::CMD_SHUTDOWN) begin
      shutdown_seen = 1'b1;
    end else if (!in_range) begin
      r.status = fsos_pkg::STS_OUT_RANGE;
    end else if (it.cmd == fsos_pkg::CMD_PROD_DONE) begin
      if ((reg_pmask & pbit) == '0) begin
        r.status = fsos_pkg::STS_NOT_REG;
      end else if ((prod_done_q[f] & pbit) != '0) begin
        r.status = fsos_pkg::STS_DONE;
      end else begin
        prod_done_q[f] = prod_done_q[f] | pbit;
        if ((prod_done_q[f] & reg_pmask) == reg_pmask) begin
          prod_done_q[f] = '0;
          set_frame_full(f, 1'b1);
          r.became_full = 1'b1;
          if ((cons_done_q[f] & reg_cmask) == reg_cmask) begin
            set_frame_full(f, 1'b0);
            cons_done_q[f] = '0;
            r.became_empty = 1'b1;
          end
        end
      end
    end else if (it.cmd == fsos_pkg::CMD_CONS_DONE) begin
      if ((reg_cmask & cbit) == '0) begin
        r.status = fsos_pkg::STS_NOT_REG;
      end else if ((cons_done_q[f] & cbit) != '0) begin
        r.status = fsos_pkg::STS_DONE;
      end else begin
        cons_done_q[f] = cons_done_q[f] | cbit;
        if ((cons_done_q[f] & reg_cmask) == reg_cmask) begin
          if (reg_zero) begin
            r.start_zeroing = 1'b1;
          end else begin
            set_frame_full(f, 1'b0);
            cons_done_q[f] = '0;
            r.became_empty = 1'b1;
          end
        end
      end
    end else if (it.cmd == fsos_pkg::CMD_ZERO_DONE) begin
      set_frame_full(f, 1'b0);
      cons_done_q[f] = '0;
      r.became_empty = 1'b1;
    end
    if (in_range) begin
      r.frame_full = frame_full_q[f];
      r.producer_may_fill = (!frame_full_q[f] && ((prod_done_q[f] & pbit) == '0)) ||
                            shutdown_seen;
      r.consumer_may_read = (frame_full_q[f] && ((cons_done_q[f] & cbit) == '0)) ||
                            shutdown_seen;
    end
    r.full_count = full_total;
    r.shut_down = shutdown_seen;
    return r;
  endfunction

  function automatic fsos_pkg::in_item_t noise_item();
    fsos_pkg::in_item_t it;
    int                 k;
    k = $urandom_range(allow_shutdown ? 7 : 6);
    if (!allow_shutdown && k >= int'(fsos_pkg::CMD_SHUTDOWN)) k++;
    it.cmd = 3'(k);
    it.frame_index = 6'($urandom_range(63));
    it.producer_index = 3'($urandom_range(7));
    it.consumer_index = 3'($urandom_range(7));
    return it;
  endfunction

  function automatic void add_item(logic [fsos_pkg::CMD_W-1:0] cmd,
                                   logic [fsos_pkg::FRAME_W-1:0] f,
                                   logic [fsos_pkg::SLOT_W-1:0] p,
                                   logic [fsos_pkg::SLOT_W-1:0] c);
    plan_row_t r;
    r.kind = ROW_ITEM;
    r.item = {cmd, f, p, c};
    r.reg_idx = '0;
    r.reg_val = '0;
    r.typed = 1'b0;
    r.want = '0;
    plan.push_back(r);
  endfunction

  // expected value typed in: full 0, read 0, count 0, no shutdown
  function automatic void add_typed(logic [fsos_pkg::CMD_W-1:0] cmd,
                                    logic [fsos_pkg::FRAME_W-1:0] f,
                                    logic [fsos_pkg::SLOT_W-1:0] p,
                                    logic [fsos_pkg::SLOT_W-1:0] c,
                                    logic [fsos_pkg::STATUS_W-1:0] st, logic fill);
    plan_row_t r;
    r.kind = ROW_ITEM;
    r.item = {cmd, f, p, c};
    r.reg_idx = '0;
    r.reg_val = '0;
    r.typed = 1'b1;
    r.want = '0;
    r.want.status = st;
    r.want.producer_may_fill = fill;
    plan.push_back(r);
  endfunction

  function automatic void add_reg(logic [fsos_pkg::CFG_IDX_W-1:0] idx,
                                  logic [fsos_pkg::CFG_DATA_W-1:0] val);
    plan_row_t r;
    r.kind = ROW_REG;
    r.item = '0;
    r.reg_idx = idx;
    r.reg_val = val;
    r.typed = 1'b0;
    r.want = '0;
    plan.push_back(r);
  endfunction

  task automatic write_reg(input logic [fsos_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fsos_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      fsos_pkg::REG_FRAMES_IN_USE: reg_frames = val[fsos_pkg::COUNT_W-1:0];
      fsos_pkg::REG_PRODUCER_MASK: reg_pmask = val;
      fsos_pkg::REG_CONSUMER_MASK: reg_cmask = val;
      fsos_pkg::REG_ZERO_ON_EMPTY: reg_zero = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int frames, input logic [fsos_pkg::MASK_W-1:0] pm,
                                input logic [fsos_pkg::MASK_W-1:0] cm, input logic z);
    write_reg(fsos_pkg::REG_FRAMES_IN_USE, 8'(frames));
    write_reg(fsos_pkg::REG_PRODUCER_MASK, pm);
    write_reg(fsos_pkg::REG_CONSUMER_MASK, cm);
    write_reg(fsos_pkg::REG_ZERO_ON_EMPTY, {7'd0, z});
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_pct <= 0;
        recv_pct <= 0;
      end
      IDLE_SENDER: begin
        send_pct <= 56;
        recv_pct <= 0;
      end
      IDLE_RECEIVER: begin
        send_pct <= 0;
        recv_pct <= 56;
      end
      default: begin
        send_pct <= 15;
        recv_pct <= 15;
      end
    endcase
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_item(input fsos_pkg::in_item_t it, input bit typed,
                           input fsos_pkg::out_item_t want);
    fsos_pkg::out_item_t predicted;
    int                  gap;
    in_ch.data <= it;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predicted = advance_ownership(it);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_pct) gap++;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send(input logic [fsos_pkg::CMD_W-1:0] cmd,
                      input logic [fsos_pkg::FRAME_W-1:0] f,
                      input logic [fsos_pkg::SLOT_W-1:0] p,
                      input logic [fsos_pkg::SLOT_W-1:0] c);
    push_item({cmd, f, p, c}, 1'b0, '0);
  endtask

  task automatic run_plan();
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        push_item(plan[i].item, plan[i].typed, plan[i].want);
      end
    end
    plan.delete();
  endtask

  // one frame through fill, read and optional zeroing, with some noise and broken steps
  task automatic run_frame_cycle();
    int lim;
    int f;
    int start;
    int stride;
    int k;
    int idx;
    lim = (reg_frames > fsos_pkg::MAX_FRAMES_DEF) ? fsos_pkg::MAX_FRAMES_DEF : reg_frames;
    f = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(lim - 1);
    start = $urandom_range(7);
    stride = 2 * $urandom_range(3) + 1;
    for (k = 0; k < 8; k++) begin
      idx = (start + k * stride) % 8;
      if (reg_pmask[idx] && $urandom_range(19) != 0) begin
        send(fsos_pkg::CMD_PROD_DONE, 6'(f), 3'(idx), 3'($urandom_range(7)));
        if ($urandom_range(19) == 0) begin
          send(fsos_pkg::CMD_PROD_DONE, 6'(f), 3'(idx), 3'($urandom_range(7)));
        end
        if ($urandom_range(7) == 0) push_item(noise_item(), 1'b0, '0);
      end
    end
    if ($urandom_range(3) == 0) begin
      send(fsos_pkg::CMD_QUERY, 6'(f), 3'($urandom_range(7)), 3'($urandom_range(7)));
    end
    start = $urandom_range(7);
    stride = 2 * $urandom_range(3) + 1;
    for (k = 0; k < 8; k++) begin
      idx = (start + k * stride) % 8;
      if (reg_cmask[idx] && $urandom_range(19) != 0) begin
        send(fsos_pkg::CMD_CONS_DONE, 6'(f), 3'($urandom_range(7)), 3'(idx));
        if ($urandom_range(19) == 0) begin
          send(fsos_pkg::CMD_CONS_DONE, 6'(f), 3'($urandom_range(7)), 3'(idx));
        end
        if ($urandom_range(7) == 0) push_item(noise_item(), 1'b0, '0);
      end
    end
    if (reg_zero && $urandom_range(9) != 0) begin
      send(fsos_pkg::CMD_ZERO_DONE, 6'(f), 3'($urandom_range(7)), 3'($urandom_range(7)));
    end
    if ($urandom_range(1) == 0) push_item(noise_item(), 1'b0, '0);
    else send(fsos_pkg::CMD_QUERY, 6'(f), 3'($urandom_range(7)), 3'($urandom_range(7)));
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (holding) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_pct);
  end

  always begin
    @(hold_off_ev);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t ns: result %h with no transfer pending", $time, out_ch.data);
      end else begin
        oldest = pending_results.pop_front();
        check_field("status", oldest.status, out_ch.data.status);
        check_field("frame_full", oldest.frame_full, out_ch.data.frame_full);
        check_field("producer_may_fill", oldest.producer_may_fill,
                    out_ch.data.producer_may_fill);
        check_field("consumer_may_read", oldest.consumer_may_read,
                    out_ch.data.consumer_may_read);
        check_field("became_full", oldest.became_full, out_ch.data.became_full);
        check_field("became_empty", oldest.became_empty, out_ch.data.became_empty);
        check_field("start_zeroing", oldest.start_zeroing, out_ch.data.start_zeroing);
        check_field("full_count", oldest.full_count, out_ch.data.full_count);
        check_field("shut_down", oldest.shut_down, out_ch.data.shut_down);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int phase;
    int mark;
    bit paused;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= fsos_pkg::REG_FRAMES_IN_USE;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    reg_frames = fsos_pkg::FRAMES_IN_USE_RST;
    reg_pmask = '0;
    reg_cmask = '0;
    reg_zero = 1'b0;
    for (int i = 0; i < fsos_pkg::MAX_FRAMES_DEF; i++) begin
      frame_full_q[i] = 1'b0;
      prod_done_q[i] = '0;
      cons_done_q[i] = '0;
    end
    full_total = '0;
    shutdown_seen = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(IDLE_NONE);
    add_typed(fsos_pkg::CMD_QUERY,     6'd0,  3'd0, 3'd0, fsos_pkg::STS_OK,        1'b1);
    add_typed(fsos_pkg::CMD_PROD_DONE, 6'd63, 3'd7, 3'd0, fsos_pkg::STS_NOT_REG,   1'b1);
    add_typed(fsos_pkg::CMD_CONS_DONE, 6'd63, 3'd0, 3'd7, fsos_pkg::STS_NOT_REG,   1'b1);
    add_reg(fsos_pkg::REG_FRAMES_IN_USE, 8'd1);
    add_typed(fsos_pkg::CMD_QUERY,     6'd1,  3'd0, 3'd0, fsos_pkg::STS_OUT_RANGE, 1'b0);
    add_typed(fsos_pkg::CMD_ZERO_DONE, 6'd63, 3'd7, 3'd7, fsos_pkg::STS_OUT_RANGE, 1'b0);
    add_item(fsos_pkg::CMD_PROD_DONE, 6'd0, 3'd0, 3'd0);
    add_reg(fsos_pkg::REG_FRAMES_IN_USE, 8'd64);
    add_reg(fsos_pkg::REG_PRODUCER_MASK, 8'h81);
    add_reg(fsos_pkg::REG_CONSUMER_MASK, 8'h81);
    add_reg(fsos_pkg::REG_ZERO_ON_EMPTY, 8'd0);
    add_item(fsos_pkg::CMD_PROD_DONE, 6'd0, 3'd0, 3'd0);
    add_item(fsos_pkg::CMD_PROD_DONE, 6'd0, 3'd0, 3'd0);
    add_item(fsos_pkg::CMD_PROD_DONE, 6'd0, 3'd3, 3'd0);
    add_item(fsos_pkg::CMD_PROD_DONE, 6'd0, 3'd7, 3'd0);
    add_item(fsos_pkg::CMD_CONS_DONE, 6'd0, 3'd0, 3'd0);
    add_item(fsos_pkg::CMD_CONS_DONE, 6'd0, 3'd0, 3'd0);
    add_item(fsos_pkg::CMD_CONS_DONE, 6'd0, 3'd0, 3'd7);
    add_item(fsos_pkg::CMD_CONS_DONE, 6'd5, 3'd0, 3'd0);
    add_item(fsos_pkg::CMD_CONS_DONE, 6'd5, 3'd0, 3'd7);
    add_item(fsos_pkg::CMD_PROD_DONE, 6'd2, 3'd0, 3'd0);
    add_item(fsos_pkg::CMD_PROD_DONE, 6'd2, 3'd7, 3'd0);
    add_item(fsos_pkg::CMD_PROD_DONE, 6'd2, 3'd0, 3'd0);
    add_item(fsos_pkg::CMD_PROD_DONE, 6'd2, 3'd7, 3'd0);
    add_reg(fsos_pkg::REG_ZERO_ON_EMPTY, 8'd1);
    add_item(fsos_pkg::CMD_CONS_DONE, 6'd2, 3'd0, 3'd0);
    add_item(fsos_pkg::CMD_CONS_DONE, 6'd2, 3'd0, 3'd7);
    add_item(fsos_pkg::CMD_ZERO_DONE, 6'd2, 3'd0, 3'd7);
    add_item(fsos_pkg::CMD_ZERO_DONE, 6'd9, 3'd0, 3'd0);
    add_reg(fsos_pkg::REG_CONSUMER_MASK, 8'h00);
    add_item(fsos_pkg::CMD_PROD_DONE, 6'd3, 3'd0, 3'd0);
    add_item(fsos_pkg::CMD_PROD_DONE, 6'd3, 3'd7, 3'd0);
    add_item(3'd5, 6'd63, 3'd7, 3'd7);
    add_item(3'd7, 6'd0, 3'd0, 3'd0);
    run_plan();

    for (phase = 0; phase < 8; phase++) begin
      wait_idle();
      case (phase)
        0: apply_settings(64, 8'hFF, 8'hFF, 1'b0);
        1: apply_settings(1, 8'h01, 8'h80, 1'b1);
        2: apply_settings(4, 8'h0F, 8'h03, 1'b0);
        3: apply_settings(64, 8'h00, 8'hFF, 1'b1);
        4: apply_settings(100, 8'hA5, 8'h00, 1'b0);
        7: apply_settings(64, 8'hFF, 8'h01, 1'b1);
        default: apply_settings($urandom_range(64, 1), 8'($urandom_range(255)),
                                8'($urandom_range(255)), 1'($urandom_range(1)));
      endcase
      set_idling(idle_mode_t'(phase % 4));
      mark = items_sent;
      paused = 1'b0;
      while (items_sent - mark < PHASE_ITEMS) begin
        if (!paused && items_sent - mark >= PHASE_ITEMS / 2) begin
          paused = 1'b1;
          if (phase == 2) -> hold_off_ev;
          else if (phase == 1 || phase == 5) wait_idle();
        end
        run_frame_cycle();
      end
    end

    // shutdown is sticky, so it is exercised last
    wait_idle();
    set_idling(IDLE_NONE);
    add_reg(fsos_pkg::REG_FRAMES_IN_USE, 8'd0);
    add_item(fsos_pkg::CMD_QUERY, 6'd0, 3'd0, 3'd0);
    add_item(fsos_pkg::CMD_SHUTDOWN, 6'd5, 3'd0, 3'd0);
    add_reg(fsos_pkg::REG_FRAMES_IN_USE, 8'd64);
    add_reg(fsos_pkg::REG_PRODUCER_MASK, 8'hFF);
    add_reg(fsos_pkg::REG_CONSUMER_MASK, 8'hFF);
    add_reg(fsos_pkg::REG_ZERO_ON_EMPTY, 8'd0);
    add_item(fsos_pkg::CMD_QUERY, 6'd0, 3'd0, 3'd0);
    add_item(fsos_pkg::CMD_PROD_DONE, 6'd0, 3'd0, 3'd0);
    add_item(fsos_pkg::CMD_CONS_DONE, 6'd0, 3'd0, 3'd0);
    run_plan();
    allow_shutdown = 1'b1;
    set_idling(IDLE_BOTH);
    mark = items_sent;
    while (items_sent - mark < TAIL_ITEMS) run_frame_cycle();

    wait_idle();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
